FILE: rtl/paf_pkg.sv
package paf_pkg;

  localparam int DIMENSIONS_DEFAULT    = 3;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam logic [31:0] PI_FIXED = 32'd3373259426;
  localparam int          PI_BITS  = 30;

  localparam int D_W    = 33;
  localparam int SQ_W   = 66;
  localparam int A_W    = 64;
  localparam int QDIV_W = 62;
  localparam int Q_W    = 61;
  localparam int QQ_W   = 2 * Q_W;
  localparam int T_W    = 89;
  localparam int T_LO_W = 33;
  localparam int T_HI_W = T_W - T_LO_W;
  localparam int WP_W   = 64 + D_W;

  localparam logic [1:0] ST_COMPUTED   = 2'd0;
  localparam logic [1:0] ST_BEYOND     = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;

  localparam int         CFG_IW         = 2;
  localparam logic [1:0] REG_ENERGY     = 2'd0;
  localparam logic [1:0] REG_USE_CUTOFF = 2'd1;
  localparam logic [1:0] REG_CUTOFF     = 2'd2;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [31:0]        first_radius;
    logic [31:0]        second_radius;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         status;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] dmag;
    logic [2:0]          dneg;
    logic [63:0]         pe;
    logic [1:0]          status;
    logic                ovf;
    logic                tneg;
  } ctx_t;

  function automatic int limbs(input int w);
    return (w + 31) >> 5;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/paf_mul.sv
module paf_mul #(
  parameter int WA    = 32,
  parameter int WB    = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  import paf_pkg::*;

  localparam int NA = limbs(WA);
  localparam int NB = limbs(WB);
  localparam int N  = NA * NB;
  localparam int WP = 32 * (NA + NB);

  logic [NA*32-1:0] sa   [DEPTH];
  logic [NB*32-1:0] sb   [DEPTH];
  logic [WP-1:0]    sacc [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_st
    logic [NA*32-1:0] a_in;
    logic [NB*32-1:0] b_in;
    logic [WP-1:0]    acc_in;
    logic [WP-1:0]    term;

    if (j == 0) begin : g_first
      assign a_in   = (NA*32)'(a);
      assign b_in   = (NB*32)'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = sa[j-1];
      assign b_in   = sb[j-1];
      assign acc_in = sacc[j-1];
    end

    if (j < N) begin : g_pp
      localparam int I = j / NB;
      localparam int L = j % NB;
      logic [63:0] pp;
      assign pp   = a_in[I*32 +: 32] * b_in[L*32 +: 32];
      assign term = WP'(pp) << (32 * (I + L));
    end else begin : g_pad
      assign term = '0;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa[j]   <= a_in;
        sb[j]   <= b_in;
        sacc[j] <= acc_in + term;
      end
    end
  end

  assign p = sacc[DEPTH-1][WA+WB-1:0];

endmodule

FILE: rtl/paf_cell.sv
module paf_cell #(
  parameter int W  = 66,
  parameter int NW = 62,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_r,
  input  logic [W-1:0]  in_s,
  input  logic [NW-1:0] in_n,
  input  logic [NW-1:0] in_q,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_r,
  output logic [W-1:0]  out_s,
  output logic [NW-1:0] out_n,
  output logic [NW-1:0] out_q,
  output logic [SW-1:0] out_side
);

  logic [W:0] r2;
  logic [W:0] rdiff;
  logic       ge;

  assign r2    = {in_r, in_n[NW-1]};
  assign ge    = r2 >= {1'b0, in_s};
  assign rdiff = r2 - {1'b0, in_s};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r    <= ge ? rdiff[W-1:0] : r2[W-1:0];
      out_s    <= in_s;
      out_n    <= {in_n[NW-2:0], 1'b0};
      out_q    <= {in_q[NW-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule

FILE: rtl/pairwise_adhesive_force_unit.sv
// Adhesive force between two cells, one pair of centres and radii per item.
// Request channel (req_valid/req_ready, req) takes one pair per cycle unless
// the pipeline is stalled; the response channel (rsp_valid/rsp_ready, rsp)
// gives force components, status and a saturation flag, one result per pair, in order.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; index 0 is epsilon, 1 the cutoff enable, 2 the cutoff length, and
// other indexes are dropped. Write them only while no pair is in flight.
// Throughput is one pair per cycle while the pipeline advances. A pair passes
// the input stage, multiplier group 1, stages B1 and B2, the row of 62
// restoring divider cells (one quotient bit per cell), stage D1, multiplier
// group 2, stage E, multiplier group 3, stage F and the output register. The
// three groups have depths 4, 4, 4 by default, one 32x32 partial product per stage.
// Reset clears all valid flags and loads the register defaults.
// When the receiver stalls, the finished result waits in the output register
// and the pipeline keeps accepting pairs until its last stage is full, then
// holds every stage together.
module pairwise_adhesive_force_unit #(
  parameter int DIMENSIONS    = paf_pkg::DIMENSIONS_DEFAULT,
  parameter int FRACTION_BITS = paf_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  paf_pkg::pair_t            req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output paf_pkg::result_t          rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [paf_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import paf_pkg::*;

  localparam int CTXW = $bits(ctx_t);
  localparam int DG1  = limbs(D_W) * limbs(D_W);
  localparam int DG2  = imax(limbs(Q_W) * limbs(Q_W), limbs(64) * limbs(D_W));
  localparam int WW   = 96 - PI_BITS - FRACTION_BITS;
  localparam int DG3  = imax(limbs(WW) * limbs(T_HI_W), limbs(WW) * limbs(T_LO_W));
  localparam int PW   = WW + T_HI_W + 1;
  localparam logic [QDIV_W-1:0] QCAP = QDIV_W'(1) << 60;
  localparam logic [T_W-1:0]    ONE  = T_W'(1) << 32;

  logic [31:0] energy;
  logic        use_cut;
  logic [31:0] cutoff;
  logic        adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy  <= 32'(200) << FRACTION_BITS;
      use_cut <= 1'b0;
      cutoff  <= 32'(3) << (FRACTION_BITS - 1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENERGY:     energy  <= cfg_data;
        REG_USE_CUTOFF: use_cut <= cfg_data[0];
        REG_CUTOFF:     cutoff  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: separation vector
  logic signed [31:0] ca [3];
  logic signed [31:0] cb [3];
  ctx_t               s0_ctx_next;
  logic               s0_v;
  ctx_t               s0_ctx;
  logic [31:0]        s0_ra;
  logic [31:0]        s0_rb;

  assign ca[0] = req.first_x;
  assign ca[1] = req.first_y;
  assign ca[2] = req.first_z;
  assign cb[0] = req.second_x;
  assign cb[1] = req.second_y;
  assign cb[2] = req.second_z;

  always_comb begin
    logic [D_W-1:0] diff;
    s0_ctx_next = '0;
    for (int k = 0; k < 3; k++) begin
      diff = '0;
      if (k < DIMENSIONS) begin
        diff = {cb[k][31], cb[k]} - {ca[k][31], ca[k]};
      end
      s0_ctx_next.dneg[k] = diff[D_W-1];
      s0_ctx_next.dmag[k] = diff[D_W-1] ? (~diff + D_W'(1)) : diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctx <= s0_ctx_next;
      s0_ra  <= req.first_radius;
      s0_rb  <= req.second_radius;
    end
  end

  // multiplier group 1: squares and epsilon scaling
  logic [SQ_W-1:0] sq [3];
  logic [63:0]     ra2;
  logic [63:0]     rb2;
  logic [63:0]     cut2;
  logic [63:0]     pe;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    paf_mul #(.WA(D_W), .WB(D_W), .DEPTH(DG1)) u_sq (
      .clk(clk), .en(adv), .a(s0_ctx.dmag[k]), .b(s0_ctx.dmag[k]), .p(sq[k])
    );
  end

  paf_mul #(.WA(32), .WB(32), .DEPTH(DG1)) u_ra2 (
    .clk(clk), .en(adv), .a(s0_ra), .b(s0_ra), .p(ra2)
  );
  paf_mul #(.WA(32), .WB(32), .DEPTH(DG1)) u_rb2 (
    .clk(clk), .en(adv), .a(s0_rb), .b(s0_rb), .p(rb2)
  );
  paf_mul #(.WA(32), .WB(32), .DEPTH(DG1)) u_cut2 (
    .clk(clk), .en(adv), .a(cutoff), .b(cutoff), .p(cut2)
  );
  paf_mul #(.WA(32), .WB(32), .DEPTH(DG1)) u_pe (
    .clk(clk), .en(adv), .a(PI_FIXED), .b(energy), .p(pe)
  );

  logic [DG1-1:0] g1_v;
  ctx_t           g1_ctx [DG1];

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_v <= '0;
    end else if (adv) begin
      g1_v <= {g1_v[DG1-2:0], s0_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_ctx[0] <= s0_ctx;
      for (int i = 1; i < DG1; i++) g1_ctx[i] <= g1_ctx[i-1];
    end
  end

  // stage B1: squared distance and radius term
  logic            b1_v;
  ctx_t            b1_ctx_next;
  ctx_t            b1_ctx;
  logic [SQ_W-1:0] b1_s;
  logic [A_W-1:0]  b1_amag;
  logic [63:0]     b1_cut2;

  always_comb begin
    b1_ctx_next    = g1_ctx[DG1-1];
    b1_ctx_next.pe = pe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (adv) begin
      b1_v <= g1_v[DG1-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_ctx  <= b1_ctx_next;
      b1_s    <= sq[0] + sq[1] + sq[2];
      b1_amag <= (ra2 >= rb2) ? (ra2 - rb2) : (rb2 - ra2);
      b1_cut2 <= cut2;
    end
  end

  // stage B2: classify and seed the divider
  logic              b2_v;
  ctx_t              b2_ctx_next;
  ctx_t              b2_ctx;
  logic [SQ_W-1:0]   b2_s;
  logic [SQ_W-1:0]   b2_r;
  logic [QDIV_W-1:0] b2_n;

  always_comb begin
    b2_ctx_next = b1_ctx;
    if (use_cut && (b1_s >= SQ_W'(b1_cut2))) begin
      b2_ctx_next.status = ST_BEYOND;
    end else if (b1_s == '0) begin
      b2_ctx_next.status = ST_COINCIDENT;
    end else begin
      b2_ctx_next.status = ST_COMPUTED;
    end
    b2_ctx_next.ovf = SQ_W'(b1_amag[A_W-1:30]) >= b1_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (adv) begin
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_ctx <= b2_ctx_next;
      b2_s   <= b1_s;
      b2_r   <= SQ_W'(b1_amag[A_W-1:30]);
      b2_n   <= {b1_amag[29:0], 32'b0};
    end
  end

  // divider row: one quotient bit per cell
  logic              dv_v    [QDIV_W+1];
  logic [SQ_W-1:0]   dv_r    [QDIV_W+1];
  logic [SQ_W-1:0]   dv_s    [QDIV_W+1];
  logic [QDIV_W-1:0] dv_n    [QDIV_W+1];
  logic [QDIV_W-1:0] dv_q    [QDIV_W+1];
  logic [CTXW-1:0]   dv_side [QDIV_W+1];

  assign dv_v[0]    = b2_v;
  assign dv_r[0]    = b2_r;
  assign dv_s[0]    = b2_s;
  assign dv_n[0]    = b2_n;
  assign dv_q[0]    = '0;
  assign dv_side[0] = b2_ctx;

  for (genvar i = 0; i < QDIV_W; i++) begin : g_div
    paf_cell #(.W(SQ_W), .NW(QDIV_W), .SW(CTXW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(dv_v[i]), .in_r(dv_r[i]), .in_s(dv_s[i]), .in_n(dv_n[i]),
      .in_q(dv_q[i]), .in_side(dv_side[i]),
      .out_valid(dv_v[i+1]), .out_r(dv_r[i+1]), .out_s(dv_s[i+1]), .out_n(dv_n[i+1]),
      .out_q(dv_q[i+1]), .out_side(dv_side[i+1])
    );
  end

  // stage D1: cap the ratio
  logic           d1_v;
  ctx_t           d1_ctx;
  logic [Q_W-1:0] d1_q;
  ctx_t           dv_ctx;

  assign dv_ctx = ctx_t'(dv_side[QDIV_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
    end else if (adv) begin
      d1_v <= dv_v[QDIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_ctx <= dv_ctx;
      if (dv_ctx.ovf || (dv_q[QDIV_W] > QCAP)) begin
        d1_q <= QCAP[Q_W-1:0];
      end else begin
        d1_q <= dv_q[QDIV_W][Q_W-1:0];
      end
    end
  end

  // multiplier group 2: ratio squared and scaled separation
  logic [QQ_W-1:0] qq;
  logic [WP_W-1:0] wp [3];

  paf_mul #(.WA(Q_W), .WB(Q_W), .DEPTH(DG2)) u_qq (
    .clk(clk), .en(adv), .a(d1_q), .b(d1_q), .p(qq)
  );

  for (genvar k = 0; k < 3; k++) begin : g_w
    paf_mul #(.WA(64), .WB(D_W), .DEPTH(DG2)) u_w (
      .clk(clk), .en(adv), .a(d1_ctx.pe), .b(d1_ctx.dmag[k]), .p(wp[k])
    );
  end

  logic [DG2-1:0] g2_v;
  ctx_t           g2_ctx [DG2];

  always_ff @(posedge clk) begin
    if (rst) begin
      g2_v <= '0;
    end else if (adv) begin
      g2_v <= {g2_v[DG2-2:0], d1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_ctx[0] <= d1_ctx;
      for (int i = 1; i < DG2; i++) g2_ctx[i] <= g2_ctx[i-1];
    end
  end

  // stage E: one minus ratio squared
  logic [T_W-1:0]    q2;
  logic              e_v;
  ctx_t              e_ctx_next;
  ctx_t              e_ctx;
  logic [T_HI_W-1:0] e_th;
  logic [T_LO_W-1:0] e_tl;
  logic [WW-1:0]     e_w [3];
  logic [T_W-1:0]    t_mag;

  assign q2    = qq[QQ_W-2:32];
  assign t_mag = (q2 > ONE) ? (q2 - ONE) : (ONE - q2);

  always_comb begin
    e_ctx_next      = g2_ctx[DG2-1];
    e_ctx_next.tneg = q2 > ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= g2_v[DG2-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ctx <= e_ctx_next;
      e_th  <= t_mag[T_W-1:T_LO_W];
      e_tl  <= t_mag[T_LO_W-1:0];
      for (int k = 0; k < 3; k++) e_w[k] <= wp[k][95:PI_BITS+FRACTION_BITS];
    end
  end

  // multiplier group 3: scaled separation times the bracket
  logic [WW+T_HI_W-1:0] mh [3];
  logic [WW+T_LO_W-1:0] ml [3];

  for (genvar k = 0; k < 3; k++) begin : g_f
    paf_mul #(.WA(WW), .WB(T_HI_W), .DEPTH(DG3)) u_hi (
      .clk(clk), .en(adv), .a(e_w[k]), .b(e_th), .p(mh[k])
    );
    paf_mul #(.WA(WW), .WB(T_LO_W), .DEPTH(DG3)) u_lo (
      .clk(clk), .en(adv), .a(e_w[k]), .b(e_tl), .p(ml[k])
    );
  end

  logic [DG3-1:0] g3_v;
  ctx_t           g3_ctx [DG3];

  always_ff @(posedge clk) begin
    if (rst) begin
      g3_v <= '0;
    end else if (adv) begin
      g3_v <= {g3_v[DG3-2:0], e_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_ctx[0] <= e_ctx;
      for (int i = 1; i < DG3; i++) g3_ctx[i] <= g3_ctx[i-1];
    end
  end

  // stage F: sum, clip, sign
  ctx_t        fc;
  result_t     f_next;
  logic        f_v;
  result_t     f_res;
  logic [31:0] comp [3];
  logic        csat [3];

  assign fc = g3_ctx[DG3-1];

  always_comb begin
    logic [PW-1:0] prod;
    logic [PW-1:0] limit;
    logic [31:0]   mag;
    logic          neg;
    for (int k = 0; k < 3; k++) begin
      prod    = PW'(mh[k]) + PW'(ml[k] >> T_LO_W);
      neg     = fc.dneg[k] ^ fc.tneg;
      limit   = neg ? (PW'(1) << 31) : ((PW'(1) << 31) - PW'(1));
      csat[k] = prod > limit;
      mag     = csat[k] ? limit[31:0] : prod[31:0];
      comp[k] = neg ? (~mag + 32'd1) : mag;
    end
    f_next        = '0;
    f_next.status = fc.status;
    if (fc.status == ST_COMPUTED) begin
      f_next.force_x   = comp[0];
      f_next.force_y   = comp[1];
      f_next.force_z   = comp[2];
      f_next.saturated = csat[0] | csat[1] | csat[2];
    end
  end

  assign adv       = !f_v || !rsp_valid || rsp_ready;
  assign req_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= g3_v[DG3-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_res <= f_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp <= f_res;
    end
  end

  a_zero_when_skipped: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_COMPUTED) |->
      (rsp.force_x == '0 && rsp.force_y == '0 && rsp.force_z == '0 && !rsp.saturated))
    else $error("skipped pair carries a nonzero force");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.saturated) |->
      (rsp.force_x == 32'h7fffffff || rsp.force_x == 32'h80000000 ||
       rsp.force_y == 32'h7fffffff || rsp.force_y == 32'h80000000 ||
       rsp.force_z == 32'h7fffffff || rsp.force_z == 32'h80000000))
    else $error("saturated flag without a clipped component");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (f_v && rsp_valid && !rsp_ready) |=> (f_v && $stable(f_res)))
    else $error("last stage lost an item under stall");

  a_unused_axis: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && DIMENSIONS < 3) |-> (rsp.force_z == '0))
    else $error("force on an unused axis");

endmodule
